// ===== design/mpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpb_pkg
// Shared types and constants for the modular power block.
// ----------------------------------------------------------------------------
package mpb_pkg;

   // Configuration register indexes.
   localparam logic CSR_MODULUS = 1'b0;
   localparam logic CSR_BASE    = 1'b1;

   // Register values after reset.
   localparam logic [63:0] RESET_MODULUS = 64'd1000003;
   localparam logic [63:0] RESET_BASE    = 64'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_SETUP,
      ST_CHECK,
      ST_MUL,
      ST_COMMIT,
      ST_DONE
   } mpb_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic step;
      logic commit_base;
      logic mul_start;
      logic commit_bit;
      logic load_out;
   } mpb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_step;
      logic exp_zero;
   } mpb_status_type;

endpackage

// ===== design/mpb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpb_datapath
// Exponent shifter, running power, accumulator and two bit-serial modular
// multiplier lanes that share one multiplier operand.
// ----------------------------------------------------------------------------
module mpb_datapath #(
   parameter int EXP_BITS = 40,
   parameter int MOD_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mpb_pkg::mpb_cmd_type  cmd,
   output mpb_pkg::mpb_status_type status,
   input  logic [EXP_BITS-1:0]   exponent,
   input  logic [MOD_BITS-1:0]   modulus,
   input  logic [MOD_BITS-1:0]   base,
   output logic [MOD_BITS-1:0]   result
);
   import mpb_pkg::*;

   localparam int CW = $clog2(MOD_BITS);

   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] run_ff, run_in;
   logic [MOD_BITS-1:0] a0_ff, a0_in;
   logic [MOD_BITS-1:0] a1_ff, a1_in;
   logic [MOD_BITS-1:0] b_ff, b_in;
   logic [MOD_BITS-1:0] r0_ff, r0_in;
   logic [MOD_BITS-1:0] r1_ff, r1_in;
   logic [MOD_BITS-1:0] result_ff, result_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [MOD_BITS:0]   mod2;
   logic [MOD_BITS-1:0] r0_next, r1_next;

   // One Horner step of an interleaved modular multiply: r = 2r + b*a mod m.
   // With r < m and a <= m the sum stays below 3m, so one of two
   // subtractions brings it back into range.
   function automatic logic [MOD_BITS-1:0] mod_step(
      input logic [MOD_BITS-1:0] r,
      input logic [MOD_BITS-1:0] a,
      input logic                bit_b,
      input logic [MOD_BITS-1:0] m,
      input logic [MOD_BITS:0]   m2
   );
      logic [MOD_BITS+1:0] t;
      t = {1'b0, r, 1'b0} + (bit_b ? {2'b00, a} : {(MOD_BITS+2){1'b0}});
      if (t >= {1'b0, m2}) begin
         t = t - {1'b0, m2};
      end else if (t >= {2'b00, m}) begin
         t = t - {2'b00, m};
      end
      return t[MOD_BITS-1:0];
   endfunction

   assign mod2    = {modulus, 1'b0};
   assign r0_next = mod_step(r0_ff, a0_ff, b_ff[MOD_BITS-1], modulus, mod2);
   assign r1_next = mod_step(r1_ff, a1_ff, b_ff[MOD_BITS-1], modulus, mod2);

   always_comb begin
      exp_in    = exp_ff;
      acc_in    = acc_ff;
      run_in    = run_ff;
      a0_in     = a0_ff;
      a1_in     = a1_ff;
      b_in      = b_ff;
      r0_in     = r0_ff;
      r1_in     = r1_ff;
      cnt_in    = cnt_ff;
      result_in = result_ff;
      if (cmd.start) begin
         // Reduce the base first: 1 * base mod m.
         exp_in = exponent;
         a0_in  = MOD_BITS'(1);
         a1_in  = '0;
         b_in   = base;
         r0_in  = '0;
         r1_in  = '0;
         cnt_in = CW'(MOD_BITS - 1);
      end
      if (cmd.mul_start) begin
         a0_in  = acc_ff;
         a1_in  = run_ff;
         b_in   = run_ff;
         r0_in  = '0;
         r1_in  = '0;
         cnt_in = CW'(MOD_BITS - 1);
      end
      if (cmd.step) begin
         r0_in  = r0_next;
         r1_in  = r1_next;
         b_in   = {b_ff[MOD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
      end
      if (cmd.commit_base) begin
         run_in = r0_ff;
         acc_in = (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
      end
      if (cmd.commit_bit) begin
         if (exp_ff[0]) begin
            acc_in = r0_ff;
         end
         run_in = r1_ff;
         exp_in = exp_ff >> 1;
      end
      if (cmd.load_out) begin
         result_in = (modulus == '0) ? '0 : acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff    <= exp_in;
      acc_ff    <= acc_in;
      run_ff    <= run_in;
      a0_ff     <= a0_in;
      a1_ff     <= a1_in;
      b_ff      <= b_in;
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign status.last_step = (cnt_ff == '0);
   assign status.exp_zero  = (exp_ff == '0);
   assign result           = result_ff;

endmodule

// ===== design/mpb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpb_ctrl
// Sequencer for base reduction, per-bit multiply passes and result handoff.
// ----------------------------------------------------------------------------
module mpb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  mpb_pkg::mpb_status_type status,
   output mpb_pkg::mpb_cmd_type    cmd
);
   import mpb_pkg::*;

   mpb_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_BASE;
            end
         end
         ST_BASE: begin
            cmd.step = 1'b1;
            if (status.last_step) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.commit_base = 1'b1;
            state_in        = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.exp_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.mul_start = 1'b1;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.step = 1'b1;
            if (status.last_step) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit_bit = 1'b1;
            state_in       = ST_CHECK;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_tready);
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== design/modular_power_of_base_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_power_of_base_top
// Computes base ** exponent mod modulus by LSB-first square-and-multiply.
// ----------------------------------------------------------------------------
// Usage:
//   An exponent arrives on the req_ stream; each accepted transaction yields
//   exactly one rsp_ transaction carrying base ** exponent mod modulus.
//   Modulus (index 0) and base (index 1) reset to 1000003 and 2. The user
//   must write them via csr_ only while the block is idle; nothing checks it.
// Multiplier and flow:
//   Every modular multiply is bit-serial, one operand bit per cycle, with
//   the square and the conditional multiply running in two lanes side by
//   side. Base reduction runs first, then one multiply pass per exponent
//   bit up to the highest set one, then the result handoff.
//   One item is in flight at a time; the next is accepted once the result
//   is in the output register.
// Reset and stall:
//   A synchronous reset empties the output register, returns the sequencer
//   to idle and restores the register reset values. While the receiver
//   stalls, the result holds in the output register and a new exponent may
//   still be accepted and worked on; it then waits until the register frees.
// ----------------------------------------------------------------------------
module modular_power_of_base_top #(
   parameter int EXP_BITS = 40,
   parameter int MOD_BITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input stream: tdata holds exponent in the low EXP_BITS bits.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((EXP_BITS+7)/8)*8-1:0]     req_tdata,
   // Result stream: tdata holds result in the low MOD_BITS bits.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((MOD_BITS+7)/8)*8-1:0]     rsp_tdata,
   // Configuration write port.
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [MOD_BITS-1:0]               csr_wdata
);
   import mpb_pkg::*;

   localparam int RSP_W = ((MOD_BITS + 7) / 8) * 8;

   logic [MOD_BITS-1:0] modulus_ff, modulus_in;
   logic [MOD_BITS-1:0] base_ff, base_in;
   logic [MOD_BITS-1:0] result;
   mpb_cmd_type         cmd;
   mpb_status_type      status;

   // Config registers; user must write only while the block is idle, unchecked.
   always_comb begin
      modulus_in = modulus_ff;
      base_in    = base_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MODULUS: modulus_in = csr_wdata;
            CSR_BASE:    base_in    = csr_wdata;
            default: begin
               modulus_in = modulus_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= RESET_MODULUS[MOD_BITS-1:0];
         base_ff    <= RESET_BASE[MOD_BITS-1:0];
      end else begin
         modulus_ff <= modulus_in;
         base_ff    <= base_in;
      end
   end

   // The sequencer owns the handshakes and the output valid flag.
   mpb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the operands, the two multiplier lanes and the
   // registered result.
   mpb_datapath #(
      .EXP_BITS (EXP_BITS),
      .MOD_BITS (MOD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .exponent (req_tdata[EXP_BITS-1:0]),
      .modulus  (modulus_ff),
      .base     (base_ff),
      .result   (result)
   );

   // Pad the result with zeros up to a whole number of bytes.
   assign rsp_tdata = RSP_W'(result);

endmodule

// ===== design/mpb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpb_checker
// Port-level checks on the modular power block, bound to its top level.
// ----------------------------------------------------------------------------
module mpb_checker #(
   parameter int MOD_BITS = 20
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [((MOD_BITS+7)/8)*8-1:0] rsp_tdata
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Only one item is worked on at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second exponent accepted while busy");

   // No item accepted while the output is empty can finish straight away.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("result appeared too early");

   // Reset leaves the output register empty.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind modular_power_of_base_top mpb_checker #(
   .MOD_BITS (MOD_BITS)
) u_mpb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/modular_power_of_base_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_power_of_base_top_tb
// Self-checking bench for the modular power block: exponent stream in,
// base ** exponent mod modulus out, under changing modulus and base settings.
// ----------------------------------------------------------------------------
module modular_power_of_base_top_tb;
   import mpb_pkg::*;

   localparam int EXP_W    = 40;
   localparam int MOD_W    = 20;
   localparam int REQ_W    = ((EXP_W + 7) / 8) * 8;
   localparam int RSP_W    = ((MOD_W + 7) / 8) * 8;
   localparam int HOLD_LEN = 1500;   // receiver hold-off, longer than any item
   localparam int PHASES   = 10;
   localparam int PER_PHASE = 125;

   localparam logic [EXP_W-1:0] EXP_ONES = {EXP_W{1'b1}};
   localparam logic [MOD_W-1:0] MOD_ONES = {MOD_W{1'b1}};

   // Expected powers and the shadow copy of the two registers.
   class mod_power_board;
      logic [MOD_W-1:0] modulus_value;
      logic [MOD_W-1:0] base_value;
      logic [MOD_W-1:0] expected_powers[$];
      int               failures;

      function new();
         modulus_value = RESET_MODULUS[MOD_W-1:0];
         base_value    = RESET_BASE[MOD_W-1:0];
         failures      = 0;
      endfunction

      function void set_reg(logic idx, logic [MOD_W-1:0] val);
         if (idx == CSR_MODULUS) begin
            modulus_value = val;
         end else begin
            base_value = val;
         end
      endfunction

      // Square-and-multiply from the low exponent bit; a zero modulus gives 0.
      function logic [MOD_W-1:0] power_mod(logic [EXP_W-1:0] e);
         logic [63:0] m;
         logic [63:0] acc;
         logic [63:0] run;
         m = {44'd0, modulus_value};
         if (m == 0) begin
            return '0;
         end
         acc = 64'd1 % m;
         run = {44'd0, base_value} % m;
         for (int i = 0; i < EXP_W; i++) begin
            if (e[i]) begin
               acc = (acc * run) % m;
            end
            run = (run * run) % m;
         end
         return acc[MOD_W-1:0];
      endfunction

      function void note_exponent(logic [EXP_W-1:0] e);
         expected_powers.push_back(power_mod(e));
      endfunction

      task report(string msg);
         $display("ERROR at %0t ns: %s", $time, msg);
         failures++;
      endtask

      task check_result(logic [MOD_W-1:0] got);
         logic [MOD_W-1:0] want;
         if (expected_powers.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected", got));
         end else begin
            want = expected_powers.pop_front();
            if (got !== want) begin
               report($sformatf("result %0d, expected %0d", got, want));
            end
         end
      endtask

      function int pending();
         return expected_powers.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;    // [39:0] exponent
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;    // [19:0] result
   logic              csr_we;
   logic              csr_index;
   logic [MOD_W-1:0]  csr_wdata;

   mod_power_board board;
   bit             calm;           // when set, neither side idles
   int             results_seen = 0;

   modular_power_of_base_top #(
      .EXP_BITS(EXP_W),
      .MOD_BITS(MOD_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Both channels are observed at the rising edge, where a transaction
   // completes. The exponent is predicted against the registers in force now.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         board.note_exponent(req_tdata[EXP_W-1:0]);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tdata[MOD_W-1:0]);
         results_seen++;
      end
   end

   // Receiver: random back-pressure, plus long hold-offs now and then so that
   // the output register stays full, the next item finishes behind it, and
   // req_tready has to drop while the sender keeps offering.
   initial begin : receiver
      int next_hold;
      rsp_tready = 1'b0;
      next_hold  = 300;
      forever begin
         @(negedge clock);
         if (results_seen >= next_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
            next_hold += 600;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 24);
         end
      end
   end

   // Offers one exponent, possibly after some idle cycles, and returns at the
   // falling edge after the transaction. Valid stays high between
   // back-to-back items.
   task send_exponent(input logic [EXP_W-1:0] e);
      while (!calm && $urandom_range(0, 99) < 24) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_W'({$urandom(), $urandom()});
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= '0;
      req_tdata[EXP_W-1:0] <= e;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stops offering and waits until every expected result has been taken.
   task drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0) @(negedge clock);
   endtask

   // Writes both registers on consecutive cycles; only called while idle.
   task configure(input logic [MOD_W-1:0] m, input logic [MOD_W-1:0] b);
      csr_we    <= 1'b1;
      csr_index <= CSR_MODULUS;
      csr_wdata <= m;
      @(negedge clock);
      board.set_reg(CSR_MODULUS, m);
      csr_index <= CSR_BASE;
      csr_wdata <= b;
      @(negedge clock);
      board.set_reg(CSR_BASE, b);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly short exponents keep the run quick; about a third draw their length
   // from the full width so every exponent bit is exercised both ways.
   function logic [EXP_W-1:0] random_exponent();
      logic [63:0] v;
      int          r;
      int          k;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         return '0;
      end else if (r < 6) begin
         return EXP_ONES;
      end
      k = (r < 70) ? $urandom_range(1, 12) : $urandom_range(1, EXP_W);
      v = {$urandom(), $urandom()};
      v = v & ((64'd1 << k) - 64'd1);
      v[k-1] = 1'b1;
      return v[EXP_W-1:0];
   endfunction

   function logic [MOD_W-1:0] random_modulus();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 20'd1;
      if (r < 20) return 20'd2;
      if (r < 30) return MOD_ONES;
      if (r < 35) return '0;       // outside the stated range, still legal
      return MOD_W'($urandom_range(3, 2 ** MOD_W - 1));
   endfunction

   function logic [MOD_W-1:0] random_base(input logic [MOD_W-1:0] m);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return MOD_ONES;
      if (r < 30) return m;
      return MOD_W'($urandom_range(0, 2 ** MOD_W - 1));
   endfunction

   initial begin : stimulus
      logic [EXP_W-1:0] corner_exps[10];
      logic [MOD_W-1:0] mods[5];
      logic [MOD_W-1:0] bases[5];
      logic [MOD_W-1:0] m;

      board        = new();
      calm         = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_we       = 1'b0;
      csr_index    = CSR_MODULUS;
      csr_wdata    = '0;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items against the reset values of modulus and base.
      corner_exps = '{40'd0, 40'd1, 40'd2, 40'd3, 40'd20, EXP_ONES,
                      40'h80_0000_0000, 40'h55_5555_5555, 40'hAA_AAAA_AAAA,
                      40'd1000002};
      foreach (corner_exps[i]) send_exponent(corner_exps[i]);

      // Modulus of one, modulus of zero, both registers at full scale,
      // the smallest useful modulus with a large base, and a zero base.
      mods  = '{20'd1, 20'd0, MOD_ONES, 20'd2, MOD_ONES};
      bases = '{20'd7, 20'd5, MOD_ONES, MOD_ONES, 20'd0};
      foreach (mods[i]) begin
         drain();
         configure(mods[i], bases[i]);
         send_exponent('0);
         send_exponent(40'd1);
         send_exponent(EXP_ONES);
      end

      // Random phases, each with its own register setting; the first goes
      // back to the reset values and one phase runs with no idling at all.
      for (int p = 0; p < PHASES; p++) begin
         drain();
         if (p == 0) begin
            configure(RESET_MODULUS[MOD_W-1:0], RESET_BASE[MOD_W-1:0]);
         end else begin
            m = random_modulus();
            configure(m, random_base(m));
         end
         calm = (p == 4);
         repeat (PER_PHASE) send_exponent(random_exponent());
      end
      calm = 1'b0;

      drain();
      // Wait longer than the longest item so that anything stray shows up.
      repeat (1000) @(negedge clock);
      if (board.pending() != 0) begin
         board.report($sformatf("%0d results never arrived", board.pending()));
      end
      if (board.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Safety net far beyond the slowest legal run.
   initial begin : watchdog
      #20000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
